// ===== hdl/kvtok_pkg.sv =====
// Package with the types, codes and character constants of the key/value tokeniser.
package kvtok_pkg;

    // Deepest word store of the original scheme; the usable bound is one less.
    localparam int unsigned WORD_BUF = 256;
    localparam logic [7:0]  WORD_MAX = 8'(WORD_BUF - 1);

    // Characters the parser reacts to.
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Parser phase, one-hot.
    typedef enum logic [7:0] {
        PH_SCOPE  = 8'b0000_0001,
        PH_OPEN   = 8'b0000_0010,
        PH_KEY    = 8'b0000_0100,
        PH_COLON  = 8'b0000_1000,
        PH_VALUE  = 8'b0001_0000,
        PH_QUOTED = 8'b0010_0000,
        PH_SEMI   = 8'b0100_0000,
        PH_ERROR  = 8'b1000_0000
    } phase_t;

    // Phase codes as seen on the output.
    typedef enum logic [2:0] {
        PC_SCOPE  = 3'd0,
        PC_OPEN   = 3'd1,
        PC_KEY    = 3'd2,
        PC_COLON  = 3'd3,
        PC_VALUE  = 3'd4,
        PC_QUOTED = 3'd5,
        PC_SEMI   = 3'd6,
        PC_ERROR  = 3'd7
    } phase_code_t;

    // Token events.
    typedef enum logic [2:0] {
        EV_SKIP     = 3'd0,
        EV_WORD     = 3'd1,
        EV_SCOPE    = 3'd2,
        EV_KEY      = 3'd3,
        EV_VALUE    = 3'd4,
        EV_CLOSE    = 3'd5,
        EV_VALCLOSE = 3'd6
    } event_t;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CHAR = 2'd1,
        ERR_LONG = 2'd2,
        ERR_END  = 2'd3
    } fault_t;

    // Map the one-hot phase onto its output code.
    function automatic phase_code_t phase_code(input phase_t ph);
        phase_code_t code;
        unique case (ph)
            PH_SCOPE:  code = PC_SCOPE;
            PH_OPEN:   code = PC_OPEN;
            PH_KEY:    code = PC_KEY;
            PH_COLON:  code = PC_COLON;
            PH_VALUE:  code = PC_VALUE;
            PH_QUOTED: code = PC_QUOTED;
            PH_SEMI:   code = PC_SEMI;
            default:   code = PC_ERROR;
        endcase
        return code;
    endfunction

    // Space, tab, carriage return and line feed.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

// ===== hdl/block_key_value_tokenizer.sv =====
// Top level of the key/value tokeniser: byte parser, state and result register.
//
// Input channel: in_valid / in_stall carry one text byte (data_byte) with the
// first and last flags. A word is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall carry one result word per input word:
// out_byte, event_res, parse_state, word_length, line_count and error_code.
// Configuration channel: cfg_valid / cfg_ready write word_limit from cfg_data;
// cfg_ready is always high; the user writes only while the block is idle, unchecked.
// Each byte goes through the parser in the cycle it is taken and its result
// sits in the output register from the next cycle.
// Throughput is one byte per cycle while out_stall is low, set by the single
// pass through the parser between the state registers and the output register.
// in_stall is raised only while a result waits and the receiver stalls, so the
// next byte is taken in the same cycle that the waiting result leaves.
// Reset (rst_n low) clears the parser state, empties the output register and
// sets word_limit to 255. A byte with first set clears the parser state too.
module block_key_value_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first,
    input  logic        last,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [2:0]  event_res,
    output logic [2:0]  parse_state,
    output logic [7:0]  word_length,
    output logic [15:0] line_count,
    output logic [1:0]  error_code
);

    // Configuration and parser state.
    logic [7:0]              limit_reg;
    kvtok_pkg::phase_t       phase_reg,   phase_next;
    logic                    comment_reg, comment_next;
    logic [7:0]              count_reg,   count_next;
    logic [15:0]             lines_reg,   lines_next;
    kvtok_pkg::fault_t       fault_reg,   fault_next;

    // Result register.
    logic                    valid_reg;
    logic [7:0]              byte_reg;
    kvtok_pkg::event_t       event_reg,   event_next;

    // State as seen after an optional restart.
    kvtok_pkg::phase_t       phase_cur;
    logic                    comment_cur;
    logic [7:0]              count_cur;
    logic [15:0]             lines_cur;
    kvtok_pkg::fault_t       fault_cur;

    logic [7:0]              ch;
    logic                    ws;
    logic [7:0]              bound;
    logic                    full;
    logic                    accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;

    // A first byte restarts the parser before it is used.
    always_comb
    begin
        if (first)
        begin
            phase_cur   = kvtok_pkg::PH_SCOPE;
            comment_cur = 1'b0;
            count_cur   = 8'd0;
            lines_cur   = 16'd0;
            fault_cur   = kvtok_pkg::ERR_NONE;
        end
        else
        begin
            phase_cur   = phase_reg;
            comment_cur = comment_reg;
            count_cur   = count_reg;
            lines_cur   = lines_reg;
            fault_cur   = fault_reg;
        end
    end

    // Comment removal: from '#' up to but not including the newline reads as space.
    always_comb
    begin
        comment_next = comment_cur;
        ch           = data_byte;
        if (!comment_cur)
        begin
            if (data_byte == kvtok_pkg::CH_HASH)
            begin
                ch           = kvtok_pkg::CH_SPACE;
                comment_next = 1'b1;
            end
        end
        else if (data_byte == kvtok_pkg::CH_LF)
        begin
            comment_next = 1'b0;
        end
        else
        begin
            ch = kvtok_pkg::CH_SPACE;
        end
    end

    assign ws    = kvtok_pkg::is_space(ch);
    assign bound = (limit_reg > kvtok_pkg::WORD_MAX) ? kvtok_pkg::WORD_MAX : limit_reg;
    assign full  = (count_cur >= bound);

    // Parser: one step per byte, then newline counting and the end-of-input check.
    always_comb
    begin
        phase_next = phase_cur;
        count_next = count_cur;
        lines_next = lines_cur;
        fault_next = fault_cur;
        event_next = kvtok_pkg::EV_SKIP;

        unique case (phase_cur)
            kvtok_pkg::PH_SCOPE:
            begin
                if (count_cur == 8'd0 && ws)
                begin
                    event_next = kvtok_pkg::EV_SKIP;
                end
                else if ((count_cur == 8'd0 && ch == kvtok_pkg::CH_LBRACE)
                         || ch == kvtok_pkg::CH_RBRACE || ch == kvtok_pkg::CH_COLON)
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_CHAR;
                end
                else if (ws || ch == kvtok_pkg::CH_LBRACE)
                begin
                    phase_next = (ch == kvtok_pkg::CH_LBRACE) ? kvtok_pkg::PH_KEY
                                                              : kvtok_pkg::PH_OPEN;
                    count_next = 8'd0;
                    event_next = kvtok_pkg::EV_SCOPE;
                end
                else if (full)
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_LONG;
                end
                else
                begin
                    count_next = count_cur + 8'd1;
                    event_next = kvtok_pkg::EV_WORD;
                end
            end
            kvtok_pkg::PH_OPEN:
            begin
                if (ws)
                begin
                    event_next = kvtok_pkg::EV_SKIP;
                end
                else if (ch == kvtok_pkg::CH_LBRACE)
                begin
                    phase_next = kvtok_pkg::PH_KEY;
                    count_next = 8'd0;
                end
                else
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_CHAR;
                end
            end
            kvtok_pkg::PH_KEY:
            begin
                if (count_cur == 8'd0 && ws)
                begin
                    event_next = kvtok_pkg::EV_SKIP;
                end
                else if (count_cur == 8'd0 && ch == kvtok_pkg::CH_RBRACE)
                begin
                    phase_next = kvtok_pkg::PH_SCOPE;
                    event_next = kvtok_pkg::EV_CLOSE;
                end
                else if ((count_cur == 8'd0 && ch == kvtok_pkg::CH_COLON)
                         || ch == kvtok_pkg::CH_LBRACE || ch == kvtok_pkg::CH_RBRACE)
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_CHAR;
                end
                else if (ws || ch == kvtok_pkg::CH_COLON)
                begin
                    phase_next = ws ? kvtok_pkg::PH_COLON : kvtok_pkg::PH_VALUE;
                    count_next = 8'd0;
                    event_next = kvtok_pkg::EV_KEY;
                end
                else if (full)
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_LONG;
                end
                else
                begin
                    count_next = count_cur + 8'd1;
                    event_next = kvtok_pkg::EV_WORD;
                end
            end
            kvtok_pkg::PH_COLON:
            begin
                if (ws)
                begin
                    event_next = kvtok_pkg::EV_SKIP;
                end
                else if (ch == kvtok_pkg::CH_COLON)
                begin
                    phase_next = kvtok_pkg::PH_VALUE;
                    count_next = 8'd0;
                end
                else
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_CHAR;
                end
            end
            kvtok_pkg::PH_VALUE:
            begin
                if (count_cur == 8'd0 && ws)
                begin
                    event_next = kvtok_pkg::EV_SKIP;
                end
                else if (count_cur == 8'd0 && ch == kvtok_pkg::CH_QUOTE)
                begin
                    phase_next = kvtok_pkg::PH_QUOTED;
                end
                else if (ch == kvtok_pkg::CH_COLON || ch == kvtok_pkg::CH_LBRACE)
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_CHAR;
                end
                else if (ch == kvtok_pkg::CH_SEMI)
                begin
                    count_next = 8'd0;
                    phase_next = kvtok_pkg::PH_KEY;
                    event_next = kvtok_pkg::EV_VALUE;
                end
                else if (ch == kvtok_pkg::CH_RBRACE)
                begin
                    count_next = 8'd0;
                    phase_next = kvtok_pkg::PH_SCOPE;
                    event_next = kvtok_pkg::EV_VALCLOSE;
                end
                else if (ws)
                begin
                    count_next = 8'd0;
                    phase_next = kvtok_pkg::PH_SEMI;
                    event_next = kvtok_pkg::EV_VALUE;
                end
                else if (full)
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_LONG;
                end
                else
                begin
                    count_next = count_cur + 8'd1;
                    event_next = kvtok_pkg::EV_WORD;
                end
            end
            kvtok_pkg::PH_QUOTED:
            begin
                if (ch == kvtok_pkg::CH_QUOTE)
                begin
                    phase_next = kvtok_pkg::PH_SEMI;
                    count_next = 8'd0;
                    event_next = kvtok_pkg::EV_VALUE;
                end
                else if (ch == kvtok_pkg::CH_CR || ch == kvtok_pkg::CH_LF)
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_CHAR;
                end
                else if (full)
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_LONG;
                end
                else
                begin
                    count_next = count_cur + 8'd1;
                    event_next = kvtok_pkg::EV_WORD;
                end
            end
            kvtok_pkg::PH_SEMI:
            begin
                if (ws)
                begin
                    event_next = kvtok_pkg::EV_SKIP;
                end
                else if (ch == kvtok_pkg::CH_SEMI)
                begin
                    phase_next = kvtok_pkg::PH_KEY;
                    count_next = 8'd0;
                end
                else if (ch == kvtok_pkg::CH_RBRACE)
                begin
                    phase_next = kvtok_pkg::PH_SCOPE;
                    count_next = 8'd0;
                    event_next = kvtok_pkg::EV_CLOSE;
                end
                else
                begin
                    phase_next = kvtok_pkg::PH_ERROR;
                    fault_next = kvtok_pkg::ERR_CHAR;
                end
            end
            default:
            begin
                // Error is sticky: nothing is parsed.
                event_next = kvtok_pkg::EV_SKIP;
            end
        endcase

        // Newlines are counted only on bytes that leave the parser healthy.
        if (phase_cur != kvtok_pkg::PH_ERROR && phase_next != kvtok_pkg::PH_ERROR
            && ch == kvtok_pkg::CH_LF && lines_cur != 16'hFFFF)
        begin
            lines_next = lines_cur + 16'd1;
        end

        // The input must end between scopes with no scope name pending.
        if (last && phase_next != kvtok_pkg::PH_ERROR
            && (phase_next != kvtok_pkg::PH_SCOPE || count_next != 8'd0))
        begin
            phase_next = kvtok_pkg::PH_ERROR;
            fault_next = kvtok_pkg::ERR_END;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 8'd255;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Parser state, updated on every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= kvtok_pkg::PH_SCOPE;
            comment_reg <= 1'b0;
            count_reg   <= 8'd0;
            lines_reg   <= 16'd0;
            fault_reg   <= kvtok_pkg::ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            count_reg   <= count_next;
            lines_reg   <= lines_next;
            fault_reg   <= fault_next;
        end
    end

    // Output valid: filled on accept, emptied when the receiver takes the word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload for the byte just taken.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= ch;
            event_reg <= event_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign event_res   = event_reg;
    assign parse_state = kvtok_pkg::phase_code(phase_reg);
    assign word_length = count_reg;
    assign line_count  = lines_reg;
    assign error_code  = fault_reg;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the key/value tokeniser: directed table, random scripts, predictor.
`timescale 1ns / 100ps

module testbench;

    import kvtok_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_WORDS = 50;
    localparam int TIMEOUT_NS  = 4_000_000;

    // One result word of the tokeniser.
    typedef struct packed {
        logic [7:0]  text;
        event_t      token;
        phase_code_t state;
        logic [7:0]  length;
        logic [15:0] lines;
        fault_t      fault;
    } token_result_t;

    // A directed input word; the expected result is typed in only where pinned is set.
    typedef struct {
        logic [7:0]  data;
        logic        restart;
        logic        at_end;
        bit          pinned;
        logic [7:0]  text;
        event_t      token;
        phase_code_t state;
        logic [7:0]  length;
        logic [15:0] lines;
        fault_t      fault;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic [2:0]  event_res;
    logic [2:0]  parse_state;
    logic [7:0]  word_length;
    logic [15:0] line_count;
    logic [1:0]  error_code;

    // Predictor state, cleared as the block is at reset.
    logic [7:0]  tk_word_limit = WORD_MAX;
    phase_code_t tk_phase      = PC_SCOPE;
    logic        tk_in_comment = 1'b0;
    logic [7:0]  tk_word_len   = 8'd0;
    logic [15:0] tk_lines      = 16'd0;
    fault_t      tk_fault      = ERR_NONE;

    token_result_t expected_tokens [$];
    logic [7:0]    script_bytes [$];
    int            bad_results  = 0;
    int            phase_words  = 0;
    bit            quiet_tail   = 1'b0;
    bit            hold_request = 1'b0;

    directed_row_t directed_rows [25] = '{
        '{"a",       1'b1, 1'b0, 1'b1, "a",   EV_WORD, PC_SCOPE, 8'd1, 16'd0, ERR_NONE},
        '{CH_SPACE,  1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_LBRACE, 1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{"k",       1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_COLON,  1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_SEMI,   1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{"q",       1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_TAB,    1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_COLON,  1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_QUOTE,  1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{8'hFF,     1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_QUOTE,  1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_RBRACE, 1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_HASH,   1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_RBRACE, 1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_LF,     1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{"x",       1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_LBRACE, 1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{"k",       1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_COLON,  1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{"v",       1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{CH_RBRACE, 1'b0, 1'b0, 1'b0, 8'h00, EV_SKIP, PC_SCOPE, 8'd0, 16'd0, ERR_NONE},
        '{"z",       1'b0, 1'b1, 1'b1, "z",   EV_WORD, PC_ERROR, 8'd1, 16'd1, ERR_END},
        '{8'h00,     1'b0, 1'b0, 1'b1, 8'h00, EV_SKIP, PC_ERROR, 8'd1, 16'd1, ERR_END},
        '{CH_COLON,  1'b1, 1'b0, 1'b1, CH_COLON, EV_SKIP, PC_ERROR, 8'd0, 16'd0, ERR_CHAR}
    };

    block_key_value_tokenizer i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .first       (first),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .event_res   (event_res),
        .parse_state (parse_state),
        .word_length (word_length),
        .line_count  (line_count),
        .error_code  (error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic event_t raise_fault(input fault_t code);
        tk_phase = PC_ERROR;
        tk_fault = code;
        return EV_SKIP;
    endfunction

    // Add a byte to the current word, or fail if the word already holds the limit.
    function automatic event_t grow_word(input phase_code_t stay);
        if (tk_word_len >= tk_word_limit)
            return raise_fault(ERR_LONG);
        tk_word_len = tk_word_len + 8'd1;
        tk_phase = stay;
        return EV_WORD;
    endfunction

    // One step of the parser on a byte that has been through comment removal.
    function automatic event_t parse_char(input logic [7:0] c);
        logic ws;
        ws = is_blank(c);
        case (tk_phase)
            PC_SCOPE:
            begin
                if (tk_word_len == 0 && ws)
                    return EV_SKIP;
                if (c == CH_RBRACE || c == CH_COLON || (tk_word_len == 0 && c == CH_LBRACE))
                    return raise_fault(ERR_CHAR);
                if (ws || c == CH_LBRACE)
                begin
                    if (c == CH_LBRACE)
                        tk_phase = PC_KEY;
                    else
                        tk_phase = PC_OPEN;
                    tk_word_len = 8'd0;
                    return EV_SCOPE;
                end
                return grow_word(PC_SCOPE);
            end
            PC_OPEN:
            begin
                if (ws)
                    return EV_SKIP;
                if (c != CH_LBRACE)
                    return raise_fault(ERR_CHAR);
                tk_phase = PC_KEY;
                tk_word_len = 8'd0;
                return EV_SKIP;
            end
            PC_KEY:
            begin
                if (tk_word_len == 0)
                begin
                    if (ws)
                        return EV_SKIP;
                    if (c == CH_COLON)
                        return raise_fault(ERR_CHAR);
                    if (c == CH_RBRACE)
                    begin
                        tk_phase = PC_SCOPE;
                        return EV_CLOSE;
                    end
                end
                if (c == CH_LBRACE || c == CH_RBRACE)
                    return raise_fault(ERR_CHAR);
                if (ws || c == CH_COLON)
                begin
                    if (ws)
                        tk_phase = PC_COLON;
                    else
                        tk_phase = PC_VALUE;
                    tk_word_len = 8'd0;
                    return EV_KEY;
                end
                return grow_word(PC_KEY);
            end
            PC_COLON:
            begin
                if (ws)
                    return EV_SKIP;
                if (c != CH_COLON)
                    return raise_fault(ERR_CHAR);
                tk_phase = PC_VALUE;
                tk_word_len = 8'd0;
                return EV_SKIP;
            end
            PC_VALUE:
            begin
                if (tk_word_len == 0)
                begin
                    if (ws)
                        return EV_SKIP;
                    if (c == CH_QUOTE)
                    begin
                        tk_phase = PC_QUOTED;
                        return EV_SKIP;
                    end
                end
                if (c == CH_COLON || c == CH_LBRACE)
                    return raise_fault(ERR_CHAR);
                if (ws || c == CH_SEMI || c == CH_RBRACE)
                begin
                    tk_word_len = 8'd0;
                    if (c == CH_SEMI)
                    begin
                        tk_phase = PC_KEY;
                        return EV_VALUE;
                    end
                    if (c == CH_RBRACE)
                    begin
                        tk_phase = PC_SCOPE;
                        return EV_VALCLOSE;
                    end
                    tk_phase = PC_SEMI;
                    return EV_VALUE;
                end
                return grow_word(PC_VALUE);
            end
            PC_QUOTED:
            begin
                if (c == CH_QUOTE)
                begin
                    tk_phase = PC_SEMI;
                    tk_word_len = 8'd0;
                    return EV_VALUE;
                end
                if (c == CH_CR || c == CH_LF)
                    return raise_fault(ERR_CHAR);
                return grow_word(PC_QUOTED);
            end
            PC_SEMI:
            begin
                if (ws)
                    return EV_SKIP;
                if (c == CH_SEMI)
                begin
                    tk_phase = PC_KEY;
                    tk_word_len = 8'd0;
                    return EV_SKIP;
                end
                if (c == CH_RBRACE)
                begin
                    tk_phase = PC_SCOPE;
                    tk_word_len = 8'd0;
                    return EV_CLOSE;
                end
                return raise_fault(ERR_CHAR);
            end
            default:
                return EV_SKIP;
        endcase
    endfunction

    // Full treatment of one input word: restart, comment removal, parse, end check.
    function automatic token_result_t tokenize_byte(input logic [7:0] raw, input logic restart,
                                                    input logic at_end);
        token_result_t res;
        logic [7:0]    c;
        event_t        token;
        if (restart)
        begin
            tk_phase = PC_SCOPE;
            tk_in_comment = 1'b0;
            tk_word_len = 8'd0;
            tk_lines = 16'd0;
            tk_fault = ERR_NONE;
        end
        if (!tk_in_comment)
        begin
            c = raw;
            if (raw == CH_HASH)
            begin
                c = CH_SPACE;
                tk_in_comment = 1'b1;
            end
        end
        else if (raw == CH_LF)
        begin
            c = raw;
            tk_in_comment = 1'b0;
        end
        else
            c = CH_SPACE;
        token = EV_SKIP;
        if (tk_phase != PC_ERROR)
        begin
            token = parse_char(c);
            if (tk_phase != PC_ERROR && c == CH_LF && tk_lines != 16'hFFFF)
                tk_lines = tk_lines + 16'd1;
        end
        // A script may only end cleanly between scopes.
        if (at_end && tk_phase != PC_ERROR && (tk_phase != PC_SCOPE || tk_word_len != 0))
            void'(raise_fault(ERR_END));
        res.text = c;
        res.token = token;
        res.state = tk_phase;
        res.length = tk_word_len;
        res.lines = tk_lines;
        res.fault = tk_fault;
        return res;
    endfunction

    // ---------------------------------------------------------------- script generation

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 255));
        while (c == CH_HASH || c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON
               || c == CH_SEMI || c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] quoted_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_CR || c == CH_LF || c == CH_HASH);
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Mostly words that fit the limit; with a small limit, now and then one that overflows it.
    function automatic int word_size();
        int n;
        if (tk_word_limit <= 16 && $urandom_range(0, 5) == 0)
            return int'(tk_word_limit) + $urandom_range(0, 1);
        n = $urandom_range(1, 6);
        if (n > tk_word_limit)
            n = tk_word_limit;
        return n;
    endfunction

    task automatic add_word(input int n);
        repeat (n) script_bytes.push_back(word_char());
    endtask

    // Nothing, white space, or a comment that runs to its line feed.
    task automatic add_spacing();
        int         n;
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0, 1:
                script_bytes.push_back(blank_char());
            2:
            begin
                script_bytes.push_back(blank_char());
                script_bytes.push_back(blank_char());
            end
            3:
            begin
                script_bytes.push_back(CH_HASH);
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_LF);
                    script_bytes.push_back(c);
                end
                script_bytes.push_back(CH_LF);
            end
            default:
                ;
        endcase
    endtask

    // A scope with a few key/value pairs, sometimes damaged or cut short.
    task automatic build_script();
        int pairs;
        bit closed;
        script_bytes.delete();
        add_word(word_size());
        add_spacing();
        script_bytes.push_back(CH_LBRACE);
        pairs = $urandom_range(0, 3);
        closed = 1'b0;
        for (int p = 0; p < pairs && !closed; p++)
        begin
            add_spacing();
            add_word(word_size());
            add_spacing();
            script_bytes.push_back(CH_COLON);
            add_spacing();
            case ($urandom_range(0, 2))
                0:
                begin
                    add_word(word_size());
                    case ($urandom_range(0, 3))
                        0: script_bytes.push_back(CH_SEMI);
                        1:
                        begin
                            script_bytes.push_back(CH_RBRACE);
                            closed = 1'b1;
                        end
                        2:
                        begin
                            script_bytes.push_back(blank_char());
                            add_spacing();
                            script_bytes.push_back(CH_SEMI);
                        end
                        default:
                        begin
                            script_bytes.push_back(blank_char());
                            script_bytes.push_back(CH_RBRACE);
                            closed = 1'b1;
                        end
                    endcase
                end
                1:
                begin
                    script_bytes.push_back(CH_QUOTE);
                    repeat (word_size()) script_bytes.push_back(quoted_char());
                    script_bytes.push_back(CH_QUOTE);
                    add_spacing();
                    script_bytes.push_back(CH_SEMI);
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        script_bytes.push_back(CH_SEMI);
                    else
                    begin
                        script_bytes.push_back(CH_RBRACE);
                        closed = 1'b1;
                    end
                end
            endcase
        end
        if (!closed)
        begin
            add_spacing();
            script_bytes.push_back(CH_RBRACE);
        end
        add_spacing();
        if ($urandom_range(0, 9) == 0)
            script_bytes[$urandom_range(0, script_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 11) == 0)
            while (script_bytes.size() > 1 && $urandom_range(0, 3) != 0)
                void'(script_bytes.pop_back());
    endtask

    // ---------------------------------------------------------------- input side

    task automatic offer_byte(input logic [7:0] b, input logic restart, input logic at_end);
        in_valid <= 1'b1;
        data_byte <= b;
        first <= restart;
        last <= at_end;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic restart, input logic at_end);
        offer_byte(b, restart, at_end);
        expected_tokens.push_back(tokenize_byte(b, restart, at_end));
        phase_words++;
        sender_gap();
    endtask

    task automatic send_script();
        logic start_fresh;
        logic mark_end;
        build_script();
        start_fresh = ($urandom_range(0, 7) != 0);
        mark_end = ($urandom_range(0, 3) != 0);
        foreach (script_bytes[i])
            send_byte(script_bytes[i], start_fresh && i == 0,
                      mark_end && i == script_bytes.size() - 1);
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_tokens.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_word_limit(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tk_word_limit = value;
    endtask

    // ---------------------------------------------------------------- output side

    // Random stall bursts, plus one long hold-off on request so that the block backs up.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            bad_results++;
            if (bad_results <= 100)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Each word taken from the block is checked against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        token_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tokens.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 100)
                    $display("%0t: unexpected result word, expected none, got byte %0h",
                             $time, out_byte);
            end
            else
            begin
                want = expected_tokens.pop_front();
                compare_field("out_byte", 16'(want.text), 16'(out_byte));
                compare_field("event_res", 16'(want.token), 16'(event_res));
                compare_field("parse_state", 16'(want.state), 16'(parse_state));
                compare_field("word_length", 16'(want.length), 16'(word_length));
                compare_field("line_count", want.lines, line_count);
                compare_field("error_code", 16'(want.fault), 16'(error_code));
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : main_sequence
        token_result_t predicted;
        logic [7:0]    limit;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= 8'h00;
        in_valid <= 1'b0;
        data_byte <= 8'h00;
        first <= 1'b0;
        last <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset word limit.
        foreach (directed_rows[i])
        begin
            offer_byte(directed_rows[i].data, directed_rows[i].restart, directed_rows[i].at_end);
            predicted = tokenize_byte(directed_rows[i].data, directed_rows[i].restart,
                                      directed_rows[i].at_end);
            if (directed_rows[i].pinned)
            begin
                predicted.text = directed_rows[i].text;
                predicted.token = directed_rows[i].token;
                predicted.state = directed_rows[i].state;
                predicted.length = directed_rows[i].length;
                predicted.lines = directed_rows[i].lines;
                predicted.fault = directed_rows[i].fault;
            end
            expected_tokens.push_back(predicted);
            sender_gap();
        end

        // Random scripts under a series of word limits; the last phase runs without idling.
        for (int k = 0; k < 8; k++)
        begin
            case (k)
                0:       limit = 8'd1;
                1:       limit = WORD_MAX;
                2:       limit = 8'd2;
                4:       limit = 8'd8;
                6:       limit = 8'd3;
                7:       limit = WORD_MAX;
                default: limit = 8'($urandom_range(1, 254));
            endcase
            drain_results();
            write_word_limit(limit);
            quiet_tail = (k == 7);
            phase_words = 0;
            // Long hold-off on the output while the input keeps coming.
            if (k == 1)
                hold_request = 1'b1;
            while (phase_words < PHASE_WORDS / 2)
                send_script();
            if (k == 2)
                drain_results();
            while (phase_words < PHASE_WORDS)
                send_script();
            // One word that reaches the largest limit and then overflows it.
            if (k == 1)
                for (int n = 0; n <= int'(WORD_MAX); n++)
                    send_byte(word_char(), n == 0, 1'b0);
        end

        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (bad_results == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #TIMEOUT_NS;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== block_key_value_tokenizer.f =====
hdl/kvtok_pkg.sv
hdl/block_key_value_tokenizer.sv
verif/testbench.sv
